// ===== design/nacc_pkg.sv =====
// shared types and constants for the nibble accumulator cpu
`default_nettype none

package nacc_pkg;

  localparam int MEM_DEPTH = 256;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int NIB_W     = 4;
  localparam int PORTS_W   = 64;

  localparam logic [MEM_AW-1:0] SP_RESET = MEM_AW'(8'hFB);

  localparam int FLAG_Z_BIT = 3;
  localparam int FLAG_N_BIT = 2;
  localparam int FLAG_C_BIT = 1;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_EXEC  = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  typedef enum logic [3:0] {
    OP_NOP = 4'h0,
    OP_LDI = 4'h1,
    OP_LDD = 4'h2,
    OP_ST  = 4'h3,
    OP_ADD = 4'h4,
    OP_SUB = 4'h5,
    OP_CMP = 4'h6,
    OP_JMP = 4'h7,
    OP_JZ  = 4'h8,
    OP_JN  = 4'h9,
    OP_JC  = 4'hA,
    OP_JSR = 4'hB,
    OP_RET = 4'hC,
    OP_IN  = 4'hD,
    OP_OUT = 4'hE,
    OP_RTI = 4'hF
  } opcode_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_REQ,
    RD_PC,
    RD_ADDR,
    RD_POP
  } rd_sel_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_REQ,
    WR_ACC,
    WR_PUSH_HI,
    WR_PUSH_LO
  } wr_sel_e;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_RDDATA,
    ACT_OPCODE,
    ACT_HI,
    ACT_LO,
    ACT_EXEC1,
    ACT_OPER,
    ACT_JUMP,
    ACT_POP
  } act_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDW,
    ST_OPC,
    ST_AHI,
    ST_ALO,
    ST_ADR,
    ST_ARG,
    ST_OPER,
    ST_PUSH,
    ST_POPI,
    ST_POPD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [MEM_AW-1:0]  mem_addr;
    logic [NIB_W-1:0]   mem_data;
    logic [PORTS_W-1:0] in_port_values;
  } req_t;

  typedef struct packed {
    logic [NIB_W-1:0]  read_data;
    logic [NIB_W-1:0]  accumulator;
    logic              zero_flag;
    logic              negative_flag;
    logic              carry_flag;
    logic [MEM_AW-1:0] program_counter;
    logic [MEM_AW-1:0] stack_pointer;
    logic              port_write;
    logic [NIB_W-1:0]  port_number;
    logic [NIB_W-1:0]  port_value;
    logic              stack_error;
  } res_t;

  typedef struct packed {
    logic       latch;
    rd_sel_e    rd;
    wr_sel_e    wr;
    act_e       act;
    logic [1:0] pop_idx;
  } cmd_t;

  typedef struct packed {
    logic [NIB_W-1:0] nib;
    logic [NIB_W-1:0] op;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/nacc_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module nacc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/nacc_ctrl.sv =====
// controller state machine sequencing fetch, operand, stack and result steps
`default_nettype none

module nacc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire logic [1:0]    req_type_i,
  input  wire nacc_pkg::sts_t sts_i,
  output logic               busy,
  output logic               done_o,
  output nacc_pkg::cmd_t     cmd_o
);
  import nacc_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] pidx_q, pidx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pidx_q  <= '0;
    end else begin
      state_q <= state_d;
      pidx_q  <= pidx_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    pidx_d        = pidx_q;
    busy          = 1'b1;
    done_o        = 1'b0;
    cmd_o.latch   = 1'b0;
    cmd_o.rd      = RD_NONE;
    cmd_o.wr      = WR_NONE;
    cmd_o.act     = ACT_NONE;
    cmd_o.pop_idx = pidx_q;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.latch = 1'b1;
          unique case (req_type_i)
            REQ_WRITE: begin
              cmd_o.wr = WR_REQ;
              state_d  = ST_DONE;
            end
            REQ_READ: begin
              cmd_o.rd = RD_REQ;
              state_d  = ST_RDW;
            end
            REQ_EXEC: begin
              cmd_o.rd = RD_PC;
              state_d  = ST_OPC;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_RDW: begin
        cmd_o.act = ACT_RDDATA;
        state_d   = ST_DONE;
      end
      ST_OPC: begin
        cmd_o.act = ACT_OPCODE;
        unique case (sts_i.nib)
          OP_NOP: state_d = ST_DONE;
          OP_LDI, OP_IN, OP_OUT: begin
            cmd_o.rd = RD_PC;
            state_d  = ST_ARG;
          end
          OP_RET: begin
            pidx_d  = 2'd2;
            state_d = ST_POPI;
          end
          OP_RTI: begin
            pidx_d  = 2'd0;
            state_d = ST_POPI;
          end
          default: begin
            cmd_o.rd = RD_PC;
            state_d  = ST_AHI;
          end
        endcase
      end
      ST_AHI: begin
        cmd_o.act = ACT_HI;
        cmd_o.rd  = RD_PC;
        state_d   = ST_ALO;
      end
      ST_ALO: begin
        cmd_o.act = ACT_LO;
        state_d   = ST_ADR;
      end
      ST_ADR: begin
        unique case (sts_i.op)
          OP_LDD, OP_ADD, OP_SUB, OP_CMP: begin
            cmd_o.rd = RD_ADDR;
            state_d  = ST_OPER;
          end
          OP_ST: begin
            cmd_o.wr = WR_ACC;
            state_d  = ST_DONE;
          end
          OP_JSR: begin
            cmd_o.wr = WR_PUSH_HI;
            state_d  = ST_PUSH;
          end
          default: begin
            cmd_o.act = ACT_JUMP;
            state_d   = ST_DONE;
          end
        endcase
      end
      ST_PUSH: begin
        cmd_o.wr  = WR_PUSH_LO;
        cmd_o.act = ACT_JUMP;
        state_d   = ST_DONE;
      end
      ST_ARG: begin
        cmd_o.act = ACT_EXEC1;
        state_d   = ST_DONE;
      end
      ST_OPER: begin
        cmd_o.act = ACT_OPER;
        state_d   = ST_DONE;
      end
      ST_POPI: begin
        cmd_o.rd = RD_POP;
        state_d  = ST_POPD;
      end
      ST_POPD: begin
        cmd_o.act = ACT_POP;
        if (pidx_q == 2'd3) begin
          state_d = ST_DONE;
        end else begin
          pidx_d  = pidx_q + 2'd1;
          state_d = ST_POPI;
        end
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/nacc_datapath.sv =====
// cpu registers, nibble memory with written marks, alu and stack logic
`default_nettype none

module nacc_datapath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire nacc_pkg::req_t req_i,
  input  wire nacc_pkg::cmd_t cmd_i,
  output nacc_pkg::sts_t      sts_o,
  output nacc_pkg::res_t      res_o
);
  import nacc_pkg::*;

  logic [NIB_W-1:0]   acc_q, acc_d;
  logic [NIB_W-1:0]   st_q, st_d;
  logic [MEM_AW-1:0]  pc_q, pc_d;
  logic [MEM_AW-1:0]  sp_q, sp_d;
  logic [NIB_W-1:0]   op_q, op_d;
  logic [NIB_W-1:0]   hi_q, hi_d;
  logic [MEM_AW-1:0]  addr_q, addr_d;
  logic [PORTS_W-1:0] ports_q, ports_d;
  logic [NIB_W-1:0]   rdd_q, rdd_d;
  logic               pw_q, pw_d;
  logic [NIB_W-1:0]   pn_q, pn_d;
  logic [NIB_W-1:0]   pv_q, pv_d;
  logic               err_q, err_d;
  logic               rmask_q, rmask_d;
  logic [MEM_DEPTH-1:0] valid_q;

  logic               ram_we;
  logic [MEM_AW-1:0]  ram_waddr;
  logic [NIB_W-1:0]   ram_wdata;
  logic [MEM_AW-1:0]  ram_raddr;
  logic [NIB_W-1:0]   ram_rdata;
  logic [NIB_W-1:0]   nib;
  logic [7:0]         ar;
  logic [NIB_W-1:0]   in_nib;
  logic               ld_en;
  logic [NIB_W-1:0]   ld_v;

  nacc_ram #(
    .WIDTH(NIB_W),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // never written entries read as nop
  assign nib    = rmask_q ? ram_rdata : '0;
  assign in_nib = ports_q[{nib, 2'b00} +: NIB_W];
  assign ar     = (op_q == OP_ADD) ? ({4'b0, acc_q} + {4'b0, nib})
                                   : ({4'b0, acc_q} - {4'b0, nib});

  assign sts_o.nib = nib;
  assign sts_o.op  = op_q;

  always_comb begin
    acc_d     = acc_q;
    st_d      = st_q;
    pc_d      = pc_q;
    sp_d      = sp_q;
    op_d      = op_q;
    hi_d      = hi_q;
    addr_d    = addr_q;
    ports_d   = ports_q;
    rdd_d     = rdd_q;
    pw_d      = pw_q;
    pn_d      = pn_q;
    pv_d      = pv_q;
    err_d     = err_q;
    ram_we    = 1'b0;
    ram_waddr = req_i.mem_addr;
    ram_wdata = req_i.mem_data;
    ram_raddr = pc_q;
    rmask_d   = 1'b0;
    ld_en     = 1'b0;
    ld_v      = nib;

    if (cmd_i.latch) begin
      ports_d = req_i.in_port_values;
      rdd_d   = '0;
      pw_d    = 1'b0;
      pn_d    = '0;
      pv_d    = '0;
      err_d   = 1'b0;
    end

    case (cmd_i.rd)
      RD_REQ: begin
        ram_raddr = req_i.mem_addr;
        rmask_d   = valid_q[ram_raddr];
      end
      RD_PC: begin
        ram_raddr = pc_q;
        rmask_d   = valid_q[ram_raddr];
        pc_d      = pc_q + 1'b1;
      end
      RD_ADDR: begin
        ram_raddr = addr_q;
        rmask_d   = valid_q[ram_raddr];
      end
      RD_POP: begin
        ram_raddr = sp_q + 1'b1;
        if (sp_q != '1) begin
          sp_d    = sp_q + 1'b1;
          rmask_d = valid_q[ram_raddr];
        end else begin
          err_d = 1'b1;
        end
      end
      default: ;
    endcase

    case (cmd_i.wr)
      WR_REQ: ram_we = 1'b1;
      WR_ACC: begin
        ram_we    = 1'b1;
        ram_waddr = addr_q;
        ram_wdata = acc_q;
      end
      WR_PUSH_HI, WR_PUSH_LO: begin
        ram_waddr = sp_q;
        ram_wdata = (cmd_i.wr == WR_PUSH_HI) ? pc_q[MEM_AW-1:NIB_W] : pc_q[NIB_W-1:0];
        if (sp_q != '0) begin
          ram_we = 1'b1;
          sp_d   = sp_q - 1'b1;
        end else begin
          err_d = 1'b1;
        end
      end
      default: ;
    endcase

    case (cmd_i.act)
      ACT_RDDATA: rdd_d = nib;
      ACT_OPCODE: op_d = nib;
      ACT_HI:     hi_d = nib;
      ACT_LO:     addr_d = {hi_q, nib};
      ACT_EXEC1: begin
        case (op_q)
          OP_LDI: ld_en = 1'b1;
          OP_IN: begin
            ld_en = 1'b1;
            ld_v  = in_nib;
          end
          OP_OUT: begin
            pw_d = 1'b1;
            pn_d = nib;
            pv_d = acc_q;
          end
          default: ;
        endcase
      end
      ACT_OPER: begin
        case (op_q)
          OP_LDD: ld_en = 1'b1;
          OP_ADD, OP_SUB, OP_CMP: begin
            st_d[FLAG_Z_BIT] = (ar == 8'h00);
            st_d[FLAG_N_BIT] = ar[3];
            st_d[FLAG_C_BIT] = |ar[7:4];
            if (op_q != OP_CMP) begin
              acc_d = ar[NIB_W-1:0];
            end
          end
          default: ;
        endcase
      end
      ACT_JUMP: begin
        case (op_q)
          OP_JMP, OP_JSR: pc_d = addr_q;
          OP_JZ: if (st_q[FLAG_Z_BIT]) pc_d = addr_q;
          OP_JN: if (st_q[FLAG_N_BIT]) pc_d = addr_q;
          OP_JC: if (st_q[FLAG_C_BIT]) pc_d = addr_q;
          default: ;
        endcase
      end
      ACT_POP: begin
        case (cmd_i.pop_idx)
          2'd0:    st_d = nib;
          2'd1:    acc_d = nib;
          2'd2:    hi_d = nib;
          default: pc_d = {nib, hi_q};
        endcase
      end
      default: ;
    endcase

    if (ld_en) begin
      acc_d            = ld_v;
      st_d[FLAG_Z_BIT] = (ld_v == '0);
      st_d[FLAG_N_BIT] = ld_v[3];
      st_d[FLAG_C_BIT] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      st_q    <= '0;
      pc_q    <= '0;
      sp_q    <= SP_RESET;
      rdd_q   <= '0;
      pw_q    <= 1'b0;
      pn_q    <= '0;
      pv_q    <= '0;
      err_q   <= 1'b0;
      rmask_q <= 1'b0;
      valid_q <= '0;
    end else begin
      acc_q   <= acc_d;
      st_q    <= st_d;
      pc_q    <= pc_d;
      sp_q    <= sp_d;
      rdd_q   <= rdd_d;
      pw_q    <= pw_d;
      pn_q    <= pn_d;
      pv_q    <= pv_d;
      err_q   <= err_d;
      rmask_q <= rmask_d;
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    hi_q    <= hi_d;
    addr_q  <= addr_d;
    ports_q <= ports_d;
  end

  assign res_o.read_data       = rdd_q;
  assign res_o.accumulator     = acc_q;
  assign res_o.zero_flag       = st_q[FLAG_Z_BIT];
  assign res_o.negative_flag   = st_q[FLAG_N_BIT];
  assign res_o.carry_flag      = st_q[FLAG_C_BIT];
  assign res_o.program_counter = pc_q;
  assign res_o.stack_pointer   = sp_q;
  assign res_o.port_write      = pw_q;
  assign res_o.port_number     = pn_q;
  assign res_o.port_value      = pv_q;
  assign res_o.stack_error     = err_q;

endmodule

`default_nettype wire

// ===== design/nibble_accumulator_cpu_unit.sv =====
// top level of the 4-bit accumulator cpu: controller plus datapath
`default_nettype none

// A request word is taken at a rising edge where start is high and busy is low.
// req_type selects a memory write, a memory read or one instruction step;
// code 3 only reports the state. Exactly one result word follows on res_o,
// marked by done_o for a single cycle; the receiver cannot stall it.
// A write or the unused code goes straight to the done step, and a read waits
// for the registered read data. An instruction step fetches the opcode, then an
// operand nibble or two address nibbles as the opcode needs, and then reads an
// operand, stores, jumps, pushes the return address or pops the stack. busy
// falls the cycle after done_o. The memory has one read and one write port, so
// one nibble is fetched, read, pushed or popped per step; read data is registered.
// Reset: accumulator, flags and pc clear, sp goes to 0xFB, and all 256 memory
// nibbles read as NOP until written (one written mark per nibble, cleared
// at reset), so no clearing pass is needed and start is taken right away.

module nibble_accumulator_cpu_unit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire nacc_pkg::req_t req_i,
  output logic                done_o,
  output nacc_pkg::res_t      res_o
);
  import nacc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  nacc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .req_type_i(req_i.req_type),
    .sts_i     (sts),
    .busy      (busy),
    .done_o    (done_o),
    .cmd_o     (cmd)
  );

  nacc_datapath u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .res_o (res_o)
  );

endmodule

`default_nettype wire
